### rtl/core/crc8fpp_pkg.sv
// Shared types, constants and CRC-8 helper for the framed packet parser.
package crc8fpp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_TOPBIT  = 8'h80;
   localparam logic [7:0] FRAME_PLEN  = 8'd4;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_SEQ     = 3'd2,
      PH_TYPE    = 3'd3,
      PH_LEN     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CRC     = 3'd6
   } phase_type;

   // One result item
   typedef struct packed {
      logic              frame_status;
      logic [7:0]        sequence_res;
      logic signed [15:0] temperature_x100;
      logic [15:0]       distance_x10;
   } result_type;

   // CRC-8, poly 0x07, MSB first, one byte per call
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((v & CRC_TOPBIT) != 8'd0) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

### rtl/core/crc8_framed_packet_parser.sv
// Top level: byte-stream frame parser with CRC-8 check and result buffering.
//
// Usage:
//   req_* carries one received byte per item (req_rx_byte). The parser hunts
//   for 0xAA 0x55, then takes sequence, type, a length byte that must be 4,
//   four payload bytes and a CRC-8 byte (poly 0x07, init 0) over sequence
//   through last payload byte. A bad second sync or length returns to hunting.
//   On the CRC byte one item leaves on rsp_*: status (0 ok, 1 mismatch),
//   sequence, signed temperature and unsigned distance (little endian).
//   Throughput: one byte per cycle while req_ready is high. The CRC update
//   and phase step are done in the cycle the byte is accepted.
//   A result is shown the cycle after its CRC byte if no older one holds rsp_*.
//   Stall: results sit in a two-entry output buffer (head and skid). Bytes
//   keep being accepted while the head waits; req_ready drops only when both
//   entries are full, and rises again once rsp_ready drains the head.
//   Reset (synchronous, active high): parser back to hunting, CRC, sequence
//   and count cleared, output buffer emptied.
module crc8_framed_packet_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_status,
   output logic [7:0]         rsp_sequence_res,
   output logic signed [15:0] rsp_temperature_x100,
   output logic [15:0]        rsp_distance_x10
);
   import crc8fpp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] crc_ff, crc_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] payload_ff [4];
   logic       pay_wr;

   result_type head_ff, head_in, skid_ff, skid_in, res;
   logic       head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;
   logic       accept, emit, push, pop;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT1:   if (req_rx_byte == SYNC_FIRST) phase_in = PH_HUNT2;
            PH_HUNT2:   phase_in = (req_rx_byte == SYNC_SECOND) ? PH_SEQ : PH_HUNT1;
            PH_SEQ:     phase_in = PH_TYPE;
            PH_TYPE:    phase_in = PH_LEN;
            PH_LEN:     phase_in = (req_rx_byte == FRAME_PLEN) ? PH_PAYLOAD : PH_HUNT1;
            PH_PAYLOAD: if ({5'd0, count_ff} + 8'd1 >= FRAME_PLEN) phase_in = PH_CRC;
            PH_CRC:     phase_in = PH_HUNT1;
            default:    phase_in = PH_HUNT1;
         endcase
      end
   end

   // Datapath updates and result assembly
   always_comb begin
      seq_in   = seq_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      pay_wr   = 1'b0;
      emit     = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_SEQ: begin
               seq_in = req_rx_byte;
               crc_in = crc8_feed(8'd0, req_rx_byte);
            end
            PH_TYPE: crc_in = crc8_feed(crc_ff, req_rx_byte);
            PH_LEN: begin
               if (req_rx_byte == FRAME_PLEN) begin
                  crc_in   = crc8_feed(crc_ff, req_rx_byte);
                  count_in = 3'd0;
               end
            end
            PH_PAYLOAD: begin
               pay_wr   = 1'b1;
               crc_in   = crc8_feed(crc_ff, req_rx_byte);
               count_in = count_ff + 3'd1;
            end
            PH_CRC:  emit = 1'b1;
            default: ;
         endcase
      end
      res.frame_status     = (req_rx_byte != crc_ff);
      res.sequence_res     = seq_ff;
      res.temperature_x100 = {payload_ff[1], payload_ff[0]};
      res.distance_x10     = {payload_ff[3], payload_ff[2]};
   end

   // Output buffer: head register plus skid entry
   assign push = emit;
   assign pop  = head_valid_ff && rsp_ready;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_in       = res;
            skid_valid_in = push;
         end else begin
            head_in       = res;
            head_valid_in = push;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = res;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT1;
         seq_ff        <= 8'd0;
         crc_ff        <= 8'd0;
         count_ff      <= 3'd0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         seq_ff        <= seq_in;
         crc_ff        <= crc_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
      if (pay_wr) begin
         payload_ff[count_ff[1:0]] <= req_rx_byte;
      end
   end

   assign rsp_valid            = head_valid_ff;
   assign rsp_frame_status     = head_ff.frame_status;
   assign rsp_sequence_res     = head_ff.sequence_res;
   assign rsp_temperature_x100 = head_ff.temperature_x100;
   assign rsp_distance_x10     = head_ff.distance_x10;

endmodule

### rtl/core/crc8fpp_checker.sv
// Port-level checker for the framed packet parser, bound to the top level.
module crc8fpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_frame_status,
   input logic [7:0]         rsp_sequence_res,
   input logic signed [15:0] rsp_temperature_x100,
   input logic [15:0]        rsp_distance_x10
);

   // Buffer comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Input only backs up when a result is already waiting
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty output");

   // A new result needs an item accepted the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid && req_ready))
      else $error("result without accepted item");

   // Stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_sequence_res) && $stable(rsp_temperature_x100)
         && $stable(rsp_distance_x10)))
      else $error("stalled result changed");

endmodule

bind crc8_framed_packet_parser crc8fpp_checker u_crc8fpp_checker (.*);

### tb/crc8_framed_packet_parser_test.sv
// Self-checking testbench for the CRC-8 framed packet parser: directed frames, random traffic.
`timescale 1ns / 1ps

module crc8_framed_packet_parser_test;
   import crc8fpp_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_frame_status;
   logic [7:0]         rsp_sequence_res;
   logic signed [15:0] rsp_temperature_x100;
   logic [15:0]        rsp_distance_x10;

   // Parser mirror state
   phase_type  frame_phase;
   logic [7:0] frame_seq;
   logic [7:0] frame_payload [4];
   logic [2:0] payload_idx;
   logic [7:0] crc_acc;

   result_type pending_results [$];
   result_type oldest;

   bit steady_stream;
   int bytes_sent;
   int frames_sent;
   int results_seen;
   int bad_crc_seen;
   int mismatch_count;

   crc8_framed_packet_parser DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_sequence_res     (rsp_sequence_res),
      .rsp_temperature_x100 (rsp_temperature_x100),
      .rsp_distance_x10     (rsp_distance_x10)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // CRC-8, poly 0x07, MSB first
   function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] v;
      v = acc ^ data;
      repeat (8) v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
      return v;
   endfunction

   // Advance the mirror by one accepted byte; queue a result on the CRC byte
   task automatic parse_byte(input logic [7:0] b);
      result_type r;
      case (frame_phase)
         PH_HUNT1: begin
            if (b == SYNC_FIRST) frame_phase = PH_HUNT2;
         end
         PH_HUNT2: begin
            // the failing byte is not re-examined as a first sync byte
            frame_phase = (b == SYNC_SECOND) ? PH_SEQ : PH_HUNT1;
         end
         PH_SEQ: begin
            frame_seq   = b;
            crc_acc     = crc_step(8'h00, b);
            frame_phase = PH_TYPE;
         end
         PH_TYPE: begin
            crc_acc     = crc_step(crc_acc, b);
            frame_phase = PH_LEN;
         end
         PH_LEN: begin
            if (b != FRAME_PLEN) begin
               frame_phase = PH_HUNT1;
            end else begin
               crc_acc     = crc_step(crc_acc, b);
               payload_idx = 3'd0;
               frame_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            frame_payload[payload_idx[1:0]] = b;
            crc_acc     = crc_step(crc_acc, b);
            payload_idx = payload_idx + 3'd1;
            if ({5'd0, payload_idx} >= FRAME_PLEN) frame_phase = PH_CRC;
         end
         PH_CRC: begin
            r.frame_status     = (b != crc_acc);
            r.sequence_res     = frame_seq;
            r.temperature_x100 = {frame_payload[1], frame_payload[0]};
            r.distance_x10     = {frame_payload[3], frame_payload[2]};
            pending_results.push_back(r);
            frame_phase = PH_HUNT1;
         end
         default: begin
            frame_phase = PH_HUNT1;
         end
      endcase
   endtask

   // Offer one byte, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_byte(input logic [7:0] b);
      while (!steady_stream && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      parse_byte(b);
      bytes_sent++;
   endtask

   // Full 10-byte frame; sync2, len and crc_flip let it be broken on purpose
   task automatic send_frame(input logic [7:0] sync2, input logic [7:0] seq,
                             input logic [7:0] ftype, input logic [7:0] len,
                             input logic [15:0] temp, input logic [15:0] distance,
                             input logic [7:0] crc_flip);
      logic [7:0] body [8];
      logic [7:0] crc;
      body = '{seq, ftype, len, temp[7:0], temp[15:8], distance[7:0], distance[15:8],
               8'h00};
      crc  = 8'h00;
      for (int i = 0; i < 7; i++) crc = crc_step(crc, body[i]);
      body[7] = crc ^ crc_flip;
      send_byte(SYNC_FIRST);
      send_byte(sync2);
      foreach (body[i]) send_byte(body[i]);
      frames_sent++;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // One chunk of random traffic: mostly good frames, some broken ones, some noise
   task automatic send_random_burst();
      int         pick;
      int         n;
      logic [7:0] flip;
      logic [7:0] s2;
      logic [7:0] len;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      flip = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (pick < 70) begin
         send_frame(SYNC_SECOND, 8'($urandom), 8'($urandom), FRAME_PLEN,
                    pick_word(), pick_word(), flip);
      end else if (pick < 78) begin
         do s2 = 8'($urandom); while (s2 == SYNC_SECOND);
         if ($urandom_range(0, 2) == 0) s2 = SYNC_FIRST;
         send_frame(s2, 8'($urandom), 8'($urandom), FRAME_PLEN,
                    pick_word(), pick_word(), flip);
      end else if (pick < 88) begin
         do begin
            len = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         end while (len == FRAME_PLEN);
         send_frame(SYNC_SECOND, 8'($urandom), 8'($urandom), len,
                    pick_word(), pick_word(), flip);
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0, 1:    b = SYNC_FIRST;
               2:       b = SYNC_SECOND;
               default: b = 8'($urandom);
            endcase
            send_byte(b);
         end
      end
   endtask

   task automatic test_directed_frames();
      // stray 0x55 after a failed second sync must not start a frame
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      // good frame at the negative temperature and full distance extremes
      send_frame(SYNC_SECOND, 8'hFF, 8'h00, FRAME_PLEN, 16'h8000, 16'hFFFF, 8'h00);
      // wrong length drops back to hunting
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h05);
      // CRC mismatch still reports the frame contents
      send_frame(SYNC_SECOND, 8'h00, 8'hFF, FRAME_PLEN, 16'h7FFF, 16'h0000, 8'h01);
   endtask

   task automatic test_random_traffic();
      while (bytes_sent < 1350) send_random_burst();
   endtask

   // Back-to-back traffic with both sides always ready
   task automatic test_steady_stream();
      int stop_at;
      stop_at = bytes_sent + 300;
      steady_stream = 1'b1;
      while (bytes_sent < stop_at) send_random_burst();
      steady_stream = 1'b0;
   endtask

   task automatic report(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   // Result check and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual seq %0d status %0d",
                     $time, rsp_sequence_res, rsp_frame_status);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_frame_status !== oldest.frame_status)
               report("frame_status", oldest.frame_status, rsp_frame_status);
            if (rsp_sequence_res !== oldest.sequence_res)
               report("sequence_res", oldest.sequence_res, rsp_sequence_res);
            if (rsp_temperature_x100 !== oldest.temperature_x100)
               report("temperature_x100", oldest.temperature_x100, rsp_temperature_x100);
            if (rsp_distance_x10 !== oldest.distance_x10)
               report("distance_x10", oldest.distance_x10, rsp_distance_x10);
            results_seen++;
            if (oldest.frame_status) bad_crc_seen++;
         end
      end
      rsp_ready <= steady_stream || ($urandom_range(0, 99) >= 31);
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = 8'h00;
      rsp_ready     = 1'b0;
      steady_stream = 1'b0;
      frame_phase   = PH_HUNT1;
      frame_seq     = 8'h00;
      payload_idx   = 3'd0;
      crc_acc       = 8'h00;
      foreach (frame_payload[i]) frame_payload[i] = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_traffic();
      test_steady_stream();
      req_valid <= 1'b0;

      // drain, then give the output buffer time to show anything stray
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes holding %0d framed sequences, with sync slips and noise.",
               bytes_sent, frames_sent);
      $display("Checked %0d results, %0d of them flagged as CRC mismatch.",
               results_seen, bad_crc_seen);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
